// ===== rtl/core/ddwo_pkg.sv =====
// Package: shared constants, types and tables for the wheel odometry block.
package ddwo_pkg;

  localparam int TAB_LEN        = 24;
  localparam int CORDIC_STEPS_D = 16;
  localparam int HWB_W          = 17;
  localparam logic [HWB_W-1:0] HWB_RESET = 17'd6554;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SC_INIT,
    ST_SC_ITER,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_AT_INIT,
    ST_AT_ITER,
    ST_AT_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic sc_init;
    logic sc_iter;
    logic mul0;
    logic mul1;
    logic mul2;
    logic mul3;
    logic at_init;
    logic at_iter;
    logic at_done;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic last_iter;
    logic coincident;
  } sts_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/ddwo_ctrl.sv =====
// Controller: sequences CORDIC, multiplies, atan2 and output handshake.
module ddwo_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  logic            out_fire,
  input  ddwo_pkg::sts_t  sts,
  output logic            in_rdy,
  output logic            out_vld,
  output ddwo_pkg::cmd_t  cmd
);

  ddwo_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ddwo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_rdy = 1'b0;
    out_vld = 1'b0;
    case (state_r)
      ddwo_pkg::ST_IDLE: begin
        in_rdy = rst_n;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = ddwo_pkg::ST_SC_INIT;
        end
      end
      ddwo_pkg::ST_SC_INIT: begin
        cmd.sc_init = 1'b1;
        state_nxt = ddwo_pkg::ST_SC_ITER;
      end
      ddwo_pkg::ST_SC_ITER: begin
        cmd.sc_iter = 1'b1;
        if (sts.last_iter) state_nxt = ddwo_pkg::ST_MUL0;
      end
      ddwo_pkg::ST_MUL0: begin
        cmd.mul0 = 1'b1;
        state_nxt = ddwo_pkg::ST_MUL1;
      end
      ddwo_pkg::ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = ddwo_pkg::ST_MUL2;
      end
      ddwo_pkg::ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = ddwo_pkg::ST_MUL3;
      end
      ddwo_pkg::ST_MUL3: begin
        cmd.mul3 = 1'b1;
        state_nxt = sts.mode ? ddwo_pkg::ST_OUT : ddwo_pkg::ST_AT_INIT;
      end
      ddwo_pkg::ST_AT_INIT: begin
        if (sts.coincident) begin
          state_nxt = ddwo_pkg::ST_OUT;
        end else begin
          cmd.at_init = 1'b1;
          state_nxt = ddwo_pkg::ST_AT_ITER;
        end
      end
      ddwo_pkg::ST_AT_ITER: begin
        cmd.at_iter = 1'b1;
        if (sts.last_iter) state_nxt = ddwo_pkg::ST_AT_DONE;
      end
      ddwo_pkg::ST_AT_DONE: begin
        cmd.at_done = 1'b1;
        state_nxt = ddwo_pkg::ST_OUT;
      end
      ddwo_pkg::ST_OUT: begin
        out_vld = 1'b1;
        if (out_fire) state_nxt = ddwo_pkg::ST_IDLE;
      end
      default: state_nxt = ddwo_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/ddwo_dp.sv =====
// Datapath: wheel point state, shared CORDIC, multiplier and output register.
module ddwo_dp #(
  parameter int CORDIC_STEPS = ddwo_pkg::CORDIC_STEPS_D
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ddwo_pkg::HWB_W-1:0] cfg_wdata,
  input  logic                       in_mode,
  input  logic signed [23:0]         in_dl,
  input  logic signed [23:0]         in_dr,
  input  logic signed [31:0]         in_sx,
  input  logic signed [31:0]         in_sy,
  input  logic signed [15:0]         in_sa,
  input  ddwo_pkg::cmd_t             cmd,
  output ddwo_pkg::sts_t             sts,
  output logic signed [31:0]         out_cx,
  output logic signed [31:0]         out_cy,
  output logic signed [15:0]         out_ang
);

  localparam int NSTEP = (CORDIC_STEPS > ddwo_pkg::TAB_LEN) ? ddwo_pkg::TAB_LEN : CORDIC_STEPS;
  localparam logic [4:0] LAST = 5'(NSTEP - 1);

  logic [ddwo_pkg::HWB_W-1:0] hwb_r;
  logic signed [31:0] lx_r, ly_r, rx_r, ry_r;
  logic [15:0] ang_r;
  logic mode_r;
  logic signed [23:0] dl_r, dr_r;
  logic signed [31:0] sx_r, sy_r;
  logic [15:0] sa_r;
  logic signed [50:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic [31:0] az_r;
  logic flip_r;
  logic [4:0] it_r;
  logic signed [33:0] sin_r, cos_r;
  logic signed [32:0] ox_r, oy_r;

  logic signed [50:0] shx, shy;
  logic dir;
  logic signed [33:0] atv;
  logic [15:0] sc_ang;
  logic [31:0] za;
  logic signed [31:0] zs;
  logic signed [23:0] mlen;
  logic signed [33:0] mfac;
  logic signed [58:0] prod;
  logic signed [32:0] mres;
  logic signed [32:0] dx, dy;
  logic signed [33:0] sum_x, sum_y;

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign sc_ang = mode_r ? sa_r : ang_r;
  assign za = {sc_ang, 16'd0};
  assign zs = za;
  assign shx = cx_r >>> it_r;
  assign shy = cy_r >>> it_r;
  assign atv = {2'b00, ddwo_pkg::atan_val(it_r)};
  assign dir = cmd.at_iter ? !cy_r[50] : !cz_r[33];

  always_comb begin
    mlen = '0;
    mfac = cos_r;
    case (1'b1)
      cmd.mul0: begin
        mlen = mode_r ? 24'(hwb_r) : dl_r;
        mfac = mode_r ? cos_r : -sin_r;
      end
      cmd.mul1: begin
        mlen = mode_r ? 24'(hwb_r) : dl_r;
        mfac = mode_r ? sin_r : cos_r;
      end
      cmd.mul2: begin
        mlen = dr_r;
        mfac = -sin_r;
      end
      cmd.mul3: begin
        mlen = dr_r;
        mfac = cos_r;
      end
      default: ;
    endcase
  end

  assign prod = 59'(mlen) * 59'(mfac) + 59'sd536870912;
  assign mres = 33'(prod >>> 30);
  assign dx = 33'(rx_r) - 33'(lx_r);
  assign dy = 33'(ry_r) - 33'(ly_r);
  assign sum_x = 34'(lx_r) + 34'(rx_r);
  assign sum_y = 34'(ly_r) + 34'(ry_r);
  assign sts.mode = mode_r;
  assign sts.last_iter = (it_r == LAST);
  assign sts.coincident = (dx == 0) && (dy == 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwb_r <= ddwo_pkg::HWB_RESET;
      lx_r <= '0;
      ly_r <= '0;
      rx_r <= '0;
      ry_r <= '0;
      ang_r <= '0;
    end else begin
      if (cfg_we) hwb_r <= cfg_wdata;
      if (cmd.mul1 && mode_r) begin
        lx_r <= sat(34'(sx_r) - 34'(ox_r));
        rx_r <= sat(34'(sx_r) + 34'(ox_r));
      end
      if (cmd.mul2 && mode_r) begin
        ly_r <= sat(34'(sy_r) - 34'(oy_r));
        ry_r <= sat(34'(sy_r) + 34'(oy_r));
        ang_r <= sa_r;
      end
      if (!mode_r) begin
        if (cmd.mul0) lx_r <= sat(34'(lx_r) + 34'(mres));
        if (cmd.mul1) ly_r <= sat(34'(ly_r) + 34'(mres));
        if (cmd.mul2) rx_r <= sat(34'(rx_r) + 34'(mres));
        if (cmd.mul3) ry_r <= sat(34'(ry_r) + 34'(mres));
      end
      if (cmd.at_done) ang_r <= 16'((az_r + 32'h8000) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      dl_r <= in_dl;
      dr_r <= in_dr;
      sx_r <= in_sx;
      sy_r <= in_sy;
      sa_r <= in_sa;
    end
    if (cmd.mul0) ox_r <= mres;
    if (cmd.mul1) oy_r <= mres;
    if (cmd.sc_init) begin
      cx_r <= 51'(ddwo_pkg::GAIN_Q30);
      cy_r <= '0;
      it_r <= '0;
      if (zs > 32'sd1073741824 || zs < -32'sd1073741824) begin
        cz_r <= 34'($signed(za + 32'h80000000));
        flip_r <= 1'b1;
      end else begin
        cz_r <= 34'(zs);
        flip_r <= 1'b0;
      end
    end
    if (cmd.sc_iter) begin
      it_r <= it_r + 5'd1;
      if (dir) begin
        cx_r <= cx_r - shy;
        cy_r <= cy_r + shx;
        cz_r <= cz_r - atv;
      end else begin
        cx_r <= cx_r + shy;
        cy_r <= cy_r - shx;
        cz_r <= cz_r + atv;
      end
      if (sts.last_iter) begin
        cos_r <= flip_r ? 34'(-(cx_r + (dir ? -shy : shy)))
                        : 34'(cx_r + (dir ? -shy : shy));
        sin_r <= flip_r ? 34'(-(cy_r + (dir ? shx : -shx)))
                        : 34'(cy_r + (dir ? shx : -shx));
      end
    end
    if (cmd.at_init) begin
      it_r <= '0;
      if (dx < 0) begin
        cx_r <= 51'(-dx) <<< 16;
        cy_r <= 51'(-dy) <<< 16;
        az_r <= 32'h80000000;
      end else begin
        cx_r <= 51'(dx) <<< 16;
        cy_r <= 51'(dy) <<< 16;
        az_r <= '0;
      end
    end
    if (cmd.at_iter) begin
      it_r <= it_r + 5'd1;
      if (dir) begin
        cx_r <= cx_r + shy;
        cy_r <= cy_r - shx;
        az_r <= az_r + atv[31:0];
      end else begin
        cx_r <= cx_r - shy;
        cy_r <= cy_r + shx;
        az_r <= az_r - atv[31:0];
      end
    end
  end

  assign out_cx = sum_x[32:1];
  assign out_cy = sum_y[32:1];
  assign out_ang = ang_r;

endmodule

// ===== rtl/core/diff_drive_wheel_odometry.sv =====
// Top level: differential-drive wheel odometry with stream ports.
// One item at a time: one shared CORDIC runs sin/cos, a single multiplier makes
// four products in turn, then, for a motion tick whose wheel points do not
// coincide, the same CORDIC runs atan2; a set-pose item and a coincident tick skip
// atan2. The result waits in the output stage until taken; the next item can be
// accepted in the cycle after it is taken.
module diff_drive_wheel_odometry #(
  parameter int CORDIC_STEPS = ddwo_pkg::CORDIC_STEPS_D
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [16:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: delta_left[23:0], delta_right[47:24], set_x[79:48], set_y[111:80],
  // set_angle[127:112]
  input  logic [127:0] s_axis_tdata,
  // tuser: mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: center_x[31:0], center_y[63:32], axle_angle[79:64]
  output logic [79:0]  m_axis_tdata
);

  ddwo_pkg::cmd_t cmd;
  ddwo_pkg::sts_t sts;
  logic signed [31:0] cx, cy;
  logic signed [15:0] ang;

  ddwo_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(s_axis_tvalid && s_axis_tready),
    .out_fire(m_axis_tvalid && m_axis_tready),
    .sts(sts), .in_rdy(s_axis_tready), .out_vld(m_axis_tvalid), .cmd(cmd)
  );

  ddwo_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_mode(s_axis_tuser),
    .in_dl(s_axis_tdata[23:0]), .in_dr(s_axis_tdata[47:24]),
    .in_sx(s_axis_tdata[79:48]), .in_sy(s_axis_tdata[111:80]),
    .in_sa(s_axis_tdata[127:112]),
    .cmd(cmd), .sts(sts), .out_cx(cx), .out_cy(cy), .out_ang(ang)
  );

  assign m_axis_tdata = {ang, cy, cx};

endmodule
